[hw/rtl/ttrc_pkg.sv]
`timescale 1ns / 1ps

package ttrc_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int FORCE_W = 20;
    localparam int EXT_W   = 24;
    localparam int ELIM_W  = 23;
    localparam int BUZZ_W  = 16;
    localparam int MM_W    = EXT_W - 8;
    localparam int MODE_W  = 2;
    localparam int DRV_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // Run states, also the run_status code
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_STOP = 2'd2
    } t_run_state;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_READING = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TARE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    // Actuator commands
    localparam logic [DRV_W-1:0] DRV_NONE = 2'd0;
    localparam logic [DRV_W-1:0] DRV_RUN  = 2'd1;
    localparam logic [DRV_W-1:0] DRV_STOP = 2'd2;

    // Stop modes (the unused code behaves as break mode)
    localparam logic [MODE_W-1:0] MODE_BREAK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXT   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_LIM    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_TICKS = 2'd3;

    localparam logic [BUZZ_W-1:0] BUZZ_TICKS_RST = 16'd5000;

    // One result beat
    typedef struct packed {
        t_run_state         run_status;
        logic               status_event;
        logic               report_reading;
        logic [DRV_W-1:0]   drive_cmd;
        logic               buzzer_on;
        logic               tare_request;
    } t_result;

endpackage

[hw/rtl/ttrc_in_if.sv]
`timescale 1ns / 1ps

interface ttrc_in_if;
    logic                                valid;
    logic                                ready;
    logic [ttrc_pkg::CMD_W-1:0]          cmd;
    logic [ttrc_pkg::FORCE_W-1:0]        force_in;
    logic signed [ttrc_pkg::EXT_W-1:0]   extension_in;

    modport source (output valid, output cmd, output force_in, output extension_in,
                    input ready);
    modport sink   (input valid, input cmd, input force_in, input extension_in,
                    output ready);
endinterface

[hw/rtl/ttrc_out_if.sv]
`timescale 1ns / 1ps

interface ttrc_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    run_status;
    logic                          status_event;
    logic                          report_reading;
    logic [ttrc_pkg::DRV_W-1:0]    drive_cmd;
    logic                          buzzer_on;
    logic                          tare_request;

    modport source (output valid, output run_status, output status_event,
                    output report_reading, output drive_cmd, output buzzer_on,
                    output tare_request, input ready);
    modport sink   (input valid, input run_status, input status_event,
                    input report_reading, input drive_cmd, input buzzer_on,
                    input tare_request, output ready);
endinterface

[hw/rtl/tensile_test_run_controller.sv]
`timescale 1ns / 1ps

// Run sequencer for one tensile test. Each input beat (reading, start/stop
// key, reset key, tare key or millisecond tick) yields exactly one result
// beat carrying the run status, event/report flags, actuator command, buzzer
// level and tare request. Beats pass through an input register, one stage of
// compare-and-transition logic that updates the run state, and an output
// register. A new beat is taken every cycle while the output accepts;
// output backpressure stalls the two registers in turn. Readings are
// published only while running and only when the force or the whole-mm
// extension changed; a run ends on the start/stop key or, per stop_mode, on
// break, force target or extension target. Configuration writes take effect
// at once and are meant to be issued while no beat is in flight.
module tensile_test_run_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ttrc_in_if.sink                             i_in,
    ttrc_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [ttrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [ttrc_pkg::MODE_W-1:0]  r_stop_mode;
    logic [ttrc_pkg::FORCE_W-1:0] r_force_lim;
    logic [ttrc_pkg::ELIM_W-1:0]  r_ext_lim;
    logic [ttrc_pkg::BUZZ_W-1:0]  r_buzz_ticks;

    // Run state
    ttrc_pkg::t_run_state         r_state, n_state;
    logic                         r_lf_vld, n_lf_vld;   // last force kept
    logic [ttrc_pkg::FORCE_W-1:0] r_last_force, n_last_force;
    logic signed [ttrc_pkg::MM_W-1:0] r_last_mm, n_last_mm;
    logic [ttrc_pkg::BUZZ_W-1:0]  r_buzz_cnt, n_buzz_cnt;

    // Input register
    logic                              r_s1_vld;
    logic [ttrc_pkg::CMD_W-1:0]        r_cmd;
    logic [ttrc_pkg::FORCE_W-1:0]      r_force;
    logic signed [ttrc_pkg::EXT_W-1:0] r_ext;

    // Output register
    logic                 r_out_vld;
    ttrc_pkg::t_result    r_res, n_res;

    logic out_load;
    logic s1_adv;

    assign out_load   = !r_out_vld || o_res.ready;
    assign s1_adv     = r_s1_vld && out_load;
    assign i_in.ready = !r_s1_vld || out_load;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_mode  <= ttrc_pkg::MODE_BREAK;
            r_force_lim  <= '0;
            r_ext_lim    <= '0;
            r_buzz_ticks <= ttrc_pkg::BUZZ_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttrc_pkg::CFG_STOP_MODE:  r_stop_mode  <= i_cfg_data[ttrc_pkg::MODE_W-1:0];
                ttrc_pkg::CFG_FORCE_LIM:  r_force_lim  <= i_cfg_data[ttrc_pkg::FORCE_W-1:0];
                ttrc_pkg::CFG_EXT_LIM:    r_ext_lim    <= i_cfg_data[ttrc_pkg::ELIM_W-1:0];
                ttrc_pkg::CFG_BUZZ_TICKS: r_buzz_ticks <= i_cfg_data[ttrc_pkg::BUZZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd   <= i_in.cmd;
            r_force <= i_in.force_in;
            r_ext   <= i_in.extension_in;
        end
    end

    // Step logic
    logic signed [ttrc_pkg::MM_W-1:0] mm;
    logic [ttrc_pkg::EXT_W-1:0]       ext_abs;
    logic                             changed;
    logic                             stop_hit;

    always_comb begin
        mm      = ttrc_pkg::MM_W'(r_ext >>> 8);
        ext_abs = r_ext[ttrc_pkg::EXT_W-1] ? ttrc_pkg::EXT_W'(-r_ext)
                                           : ttrc_pkg::EXT_W'(r_ext);
        changed = !r_lf_vld || (r_last_force != r_force) || (r_last_mm != mm);
        unique case (r_stop_mode)
            ttrc_pkg::MODE_FORCE: stop_hit = !(r_force < r_force_lim);
            ttrc_pkg::MODE_EXT:   stop_hit = ext_abs > {1'b0, r_ext_lim};
            default:              stop_hit = r_lf_vld && (r_last_force != '0)
                                             && (r_force == '0);
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_lf_vld     = r_lf_vld;
        n_last_force = r_last_force;
        n_last_mm    = r_last_mm;
        n_buzz_cnt   = r_buzz_cnt;
        n_res        = '0;

        unique case (r_cmd)
            ttrc_pkg::CMD_READING: begin
                if (r_state == ttrc_pkg::ST_RUN && changed) begin
                    n_res.report_reading = 1'b1;
                    if (stop_hit) begin
                        n_state            = ttrc_pkg::ST_STOP;
                        n_buzz_cnt         = r_buzz_ticks;
                        n_res.status_event = 1'b1;
                        n_res.drive_cmd    = ttrc_pkg::DRV_STOP;
                        if (r_stop_mode != ttrc_pkg::MODE_FORCE &&
                            r_stop_mode != ttrc_pkg::MODE_EXT) begin
                            n_lf_vld = 1'b0;
                        end
                    end else begin
                        n_res.drive_cmd = ttrc_pkg::DRV_RUN;
                        n_lf_vld        = 1'b1;
                        n_last_force    = r_force;
                        n_last_mm       = mm;
                    end
                end
            end
            ttrc_pkg::CMD_START: begin
                n_res.status_event = 1'b1;
                unique case (r_state)
                    ttrc_pkg::ST_IDLE: begin
                        n_state         = ttrc_pkg::ST_RUN;
                        n_lf_vld        = 1'b0;
                        n_res.drive_cmd = ttrc_pkg::DRV_RUN;
                    end
                    ttrc_pkg::ST_RUN: begin
                        n_state    = ttrc_pkg::ST_STOP;
                        n_buzz_cnt = r_buzz_ticks;
                    end
                    default: begin
                        n_state         = ttrc_pkg::ST_RUN;
                        n_buzz_cnt      = '0;
                        n_res.drive_cmd = ttrc_pkg::DRV_RUN;
                    end
                endcase
            end
            ttrc_pkg::CMD_RESET: begin
                n_state            = ttrc_pkg::ST_IDLE;
                n_buzz_cnt         = '0;
                n_lf_vld           = 1'b0;
                n_res.status_event = 1'b1;
                n_res.drive_cmd    = ttrc_pkg::DRV_RUN;
            end
            ttrc_pkg::CMD_TARE: begin
                n_res.tare_request = 1'b1;
            end
            ttrc_pkg::CMD_TICK: begin
                // buzzer countdown; zero ticks behaves as one
                if (r_state == ttrc_pkg::ST_STOP) begin
                    if (r_buzz_cnt > ttrc_pkg::BUZZ_W'(1)) begin
                        n_buzz_cnt = r_buzz_cnt - ttrc_pkg::BUZZ_W'(1);
                    end else begin
                        n_buzz_cnt = '0;
                        n_state    = ttrc_pkg::ST_IDLE;
                    end
                end
            end
            default: ;
        endcase

        n_res.run_status = n_state;
        n_res.buzzer_on  = (n_state == ttrc_pkg::ST_STOP);
    end

    // State update as the beat moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttrc_pkg::ST_IDLE;
            r_lf_vld   <= 1'b0;
            r_last_mm  <= '1;
            r_buzz_cnt <= '0;
        end else if (s1_adv) begin
            r_state    <= n_state;
            r_lf_vld   <= n_lf_vld;
            r_last_mm  <= n_last_mm;
            r_buzz_cnt <= n_buzz_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_last_force <= n_last_force;
            r_res        <= n_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= r_s1_vld;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.run_status     = r_res.run_status;
    assign o_res.status_event   = r_res.status_event;
    assign o_res.report_reading = r_res.report_reading;
    assign o_res.drive_cmd      = r_res.drive_cmd;
    assign o_res.buzzer_on      = r_res.buzzer_on;
    assign o_res.tare_request   = r_res.tare_request;

    // Checks
    a_idle_buzz_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ttrc_pkg::ST_IDLE |-> r_buzz_cnt == '0)
        else $error("buzz counter nonzero while idle");

    a_buzzer_tracks_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_res.buzzer_on == (r_res.run_status == ttrc_pkg::ST_STOP))
        else $error("buzzer level disagrees with run status");

    a_drive_stop_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.drive_cmd == ttrc_pkg::DRV_STOP |->
            r_res.status_event && r_res.report_reading &&
            r_res.run_status == ttrc_pkg::ST_STOP)
        else $error("stop command without stop event");

    a_report_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.report_reading |-> r_res.run_status != ttrc_pkg::ST_IDLE)
        else $error("reading published while idle");

    a_tare_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.tare_request |->
            !r_res.status_event && !r_res.report_reading)
        else $error("tare beat carries other flags");

endmodule
